[hw/rtl/assert_macros.svh]
// Assertion helper macros for the rotation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define RI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define RI_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hw/rtl/rotimg_pkg.sv]
// Package: payload types, register indexes and sizes of the rotation block
`timescale 1ns / 1ps
package rotimg_pkg;

   localparam int SRC_ROW_BITS = 8;
   localparam int SRC_COL_BITS = 8;
   localparam int MEM_ADDR_BITS = SRC_ROW_BITS + SRC_COL_BITS;
   localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
   localparam int FRAC_BITS = 15;
   localparam int POS_BITS = 9;
   localparam int PIX_BITS = 24;
   localparam int Q_BITS = 29;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_COS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIN = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_H = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_W = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DST_H = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DST_W = 3'd5;

   localparam logic ACT_STORE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic                action;
      logic [POS_BITS-1:0] pos_row;
      logic [POS_BITS-1:0] pos_col;
      logic [PIX_BITS-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_out;
      logic                inside_res;
   } rsp_type;

endpackage

[hw/rtl/rotate_image_nearest.sv]
// A query result passes through stages s1 to s5 and is presented from s5.
// Throughput: one item per cycle; all five stages advance together and stop
// only while a result waits at the output, which then also holds the input.
// Reset: synchronous; clears stage valid flags and restores register defaults.
// The image memory is not cleared; only stored pixels may be read back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotate_image_nearest
   import rotimg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   // configuration
   logic signed [15:0] cos_ff, sin_ff;
   logic [8:0]         src_h_ff, src_w_ff;
   logic [9:0]         dst_h_ff, dst_w_ff;

   // pipeline valid flags and payload registers
   logic                    s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic                    s1_act_ff, s2_act_ff, s3_act_ff, s4_act_ff;
   logic                    s1_out_ff, s2_out_ff, s3_out_ff;
   logic [POS_BITS-1:0]     s1_row_ff, s2_row_ff, s3_row_ff, s4_row_ff;
   logic [POS_BITS-1:0]     s1_col_ff, s2_col_ff, s3_col_ff, s4_col_ff;
   logic [PIX_BITS-1:0]     s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff;
   logic signed [10:0]      s1_x2_ff, s1_y2_ff;
   logic signed [26:0]      s2_xc_ff, s2_ys_ff, s2_yc_ff, s2_xs_ff;
   logic signed [Q_BITS-1:0] s3_colq_ff, s3_rowq_ff;
   logic                    s4_in_ff, s5_in_ff;
   logic [MEM_ADDR_BITS-1:0] s4_addr_ff;
   logic [PIX_BITS-1:0]     mem_q_ff;

   logic [PIX_BITS-1:0] image_mem [MEM_DEPTH];

   logic                     advance;
   logic signed [10:0]       x2_in, y2_in;
   logic                     out_in;
   logic signed [Q_BITS-1:0] colq_in, rowq_in, rlim, clim;
   logic                     in_in;
   logic [MEM_ADDR_BITS-1:0] addr_in;
   logic                     mem_we, mem_re;

   assign advance   = !s5_vld_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff   <= 16'sd16384;
         sin_ff   <= 16'sd0;
         src_h_ff <= 9'd256;
         src_w_ff <= 9'd256;
         dst_h_ff <= 10'd256;
         dst_w_ff <= 10'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COS:   cos_ff   <= $signed(csr_data);
            CSR_SIN:   sin_ff   <= $signed(csr_data);
            CSR_SRC_H: src_h_ff <= csr_data[8:0];
            CSR_SRC_W: src_w_ff <= csr_data[8:0];
            CSR_DST_H: dst_h_ff <= csr_data[9:0];
            CSR_DST_W: dst_w_ff <= csr_data[9:0];
            default:   ;
         endcase
      end
   end

   // stage 1: centre on the destination frame, with one fractional bit
   assign x2_in  = $signed({1'b0, req_payload.pos_col, 1'b0}) - $signed({1'b0, dst_w_ff});
   assign y2_in  = $signed({1'b0, req_payload.pos_row, 1'b0}) - $signed({1'b0, dst_h_ff});
   assign out_in = ({1'b0, req_payload.pos_row} >= dst_h_ff) ||
                   ({1'b0, req_payload.pos_col} >= dst_w_ff);

   // stage 3: sums in units of 2^-15 pixel
   assign colq_in = Q_BITS'(s2_xc_ff) + Q_BITS'(s2_ys_ff)
                  + $signed(Q_BITS'({src_w_ff, 14'b0}));
   assign rowq_in = Q_BITS'(s2_yc_ff) - Q_BITS'(s2_xs_ff)
                  + $signed(Q_BITS'({src_h_ff, 14'b0}));

   // stage 4: bounds; a zero size gives a negative limit, so all is outside
   assign rlim = Q_BITS'($signed({1'b0, src_h_ff}) - 10'sd1) <<< FRAC_BITS;
   assign clim = Q_BITS'($signed({1'b0, src_w_ff}) - 10'sd1) <<< FRAC_BITS;
   assign in_in = !s3_out_ff && !s3_rowq_ff[Q_BITS-1] && !s3_colq_ff[Q_BITS-1]
                  && (s3_rowq_ff <= rlim) && (s3_colq_ff <= clim)
                  && (s3_rowq_ff[Q_BITS-2:FRAC_BITS+SRC_ROW_BITS] == '0)
                  && (s3_colq_ff[Q_BITS-2:FRAC_BITS+SRC_COL_BITS] == '0);
   assign addr_in = {s3_rowq_ff[FRAC_BITS +: SRC_ROW_BITS],
                     s3_colq_ff[FRAC_BITS +: SRC_COL_BITS]};

   // stores and query reads meet the memory in the same stage, so order holds
   assign mem_we = advance && s4_vld_ff && (s4_act_ff == ACT_STORE)
                   && (s4_row_ff[POS_BITS-1:SRC_ROW_BITS] == '0)
                   && (s4_col_ff[POS_BITS-1:SRC_COL_BITS] == '0);
   assign mem_re = advance && s4_vld_ff && (s4_act_ff == ACT_QUERY) && s4_in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff && (s4_act_ff == ACT_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_act_ff  <= req_payload.action;
         s1_row_ff  <= req_payload.pos_row;
         s1_col_ff  <= req_payload.pos_col;
         s1_pix_ff  <= req_payload.pixel_in;
         s1_x2_ff   <= x2_in;
         s1_y2_ff   <= y2_in;
         s1_out_ff  <= out_in;

         s2_act_ff  <= s1_act_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_pix_ff  <= s1_pix_ff;
         s2_out_ff  <= s1_out_ff;
         s2_xc_ff   <= s1_x2_ff * cos_ff;
         s2_ys_ff   <= s1_y2_ff * sin_ff;
         s2_yc_ff   <= s1_y2_ff * cos_ff;
         s2_xs_ff   <= s1_x2_ff * sin_ff;

         s3_act_ff  <= s2_act_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_pix_ff  <= s2_pix_ff;
         s3_out_ff  <= s2_out_ff;
         s3_colq_ff <= colq_in;
         s3_rowq_ff <= rowq_in;

         s4_act_ff  <= s3_act_ff;
         s4_row_ff  <= s3_row_ff;
         s4_col_ff  <= s3_col_ff;
         s4_pix_ff  <= s3_pix_ff;
         s4_in_ff   <= in_in;
         s4_addr_ff <= addr_in;

         s5_in_ff   <= s4_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[{s4_row_ff[SRC_ROW_BITS-1:0], s4_col_ff[SRC_COL_BITS-1:0]}] <= s4_pix_ff;
      end
      if (mem_re) begin
         mem_q_ff <= image_mem[s4_addr_ff];
      end
   end

   assign rsp_valid              = s5_vld_ff;
   assign rsp_payload.inside_res = s5_in_ff;
   assign rsp_payload.pixel_out  = s5_in_ff ? mem_q_ff : '0;

   `RI_NEVER(a_mem_one_access, clock, reset, mem_we && mem_re, "write and read in one cycle")
   `RI_ASSERT(a_stall_only_on_rsp, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready), "input stalled without output backpressure")
   `RI_ASSERT(a_store_no_rsp, clock, reset, (advance && s4_vld_ff && s4_act_ff == ACT_STORE) |=> !rsp_valid, "store item gave a result")
   `RI_NEVER(a_outside_black, clock, reset, rsp_valid && !rsp_payload.inside_res && rsp_payload.pixel_out != '0, "outside point not black")

endmodule
